[rtl/atl_pkg.sv]
// Shared widths, types and constants for the accelerometer tilt-angle pipeline.
// Used by atl_sqrt, atl_cordic, atl_outq and accel_tilt_angles_core.
`timescale 1ns / 1ps

package atl_pkg;

    // Sample and magnitude widths
    localparam int IN_W       = 16;
    localparam int SQ_W       = 2 * IN_W;              // x^2 + z^2
    localparam int SQ_PAD     = 16;                    // radicand = sum << SQ_PAD (root in Q8)
    localparam int ROOT_W     = (SQ_W + SQ_PAD) / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQ_STAGES  = ROOT_W;                // one root bit per stage

    // CORDIC datapath
    localparam int CW            = 50;
    localparam int OP_SHIFT      = 30;                 // scale of raw sample operands
    localparam int ROOT_SHIFT    = 22;                 // scale of the Q8 magnitude
    localparam int ANG_W         = 24;                 // angle in 1/25600 degree
    localparam int ANG_FRAC      = 8;                  // fraction bits below one centidegree
    localparam int CORDIC_STAGES = 22;

    // Lanes of the CORDIC unit
    localparam int NLANE      = 2;
    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;

    // Result widths
    localparam int PITCH_W = 15;
    localparam int ROLL_W  = 16;
    localparam int RND_W   = ANG_W + 1 - ANG_FRAC;

    typedef logic signed [CW-1:0]    cw_t;
    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [RND_W-1:0] cdeg_t;

    localparam ang_t DEG90  = 24'sd2304000;
    localparam ang_t DEG180 = 24'sd4608000;

    localparam cdeg_t PITCH_LIM = 17'sd9000;
    localparam cdeg_t ROLL_LIM  = 17'sd18000;

    // round(atan(2^-i) degrees * 25600)
    localparam ang_t ATAN_TAB [0:CORDIC_STAGES-1] = '{
        24'sd1152000, 24'sd680065, 24'sd359328, 24'sd182400, 24'sd91554, 24'sd45822,
        24'sd22916,   24'sd11459,  24'sd5730,   24'sd2865,   24'sd1432,  24'sd716,
        24'sd358,     24'sd179,    24'sd90,     24'sd45,     24'sd22,    24'sd11,
        24'sd6,       24'sd3,      24'sd1,      24'sd1
    };

endpackage

[rtl/atl_sqrt.sv]
// Magnitude front end: squares x and z, then a restoring square-root pipeline.
// Produces floor(sqrt((x^2 + z^2) << 16)) and carries the sample along. Uses atl_pkg.
`timescale 1ns / 1ps

module atl_sqrt
    import atl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  logic                     in_valid,
    input  logic signed [IN_W-1:0]   in_x,
    input  logic signed [IN_W-1:0]   in_y,
    input  logic signed [IN_W-1:0]   in_z,
    output logic                     out_valid,
    output logic [ROOT_W-1:0]        out_root,
    output logic signed [IN_W-1:0]   out_x,
    output logic signed [IN_W-1:0]   out_y,
    output logic signed [IN_W-1:0]   out_z
);

    // Square stage
    logic                    sqa_v_reg;
    logic [SQ_W-2:0]         xx_reg;
    logic [SQ_W-2:0]         zz_reg;
    logic signed [IN_W-1:0]  ax_reg;
    logic signed [IN_W-1:0]  ay_reg;
    logic signed [IN_W-1:0]  az_reg;
    logic signed [SQ_W-1:0]  xx_prod;
    logic signed [SQ_W-1:0]  zz_prod;

    // Root stages: index 0 holds the sum, index k holds k root bits
    logic                    s_v_reg [0:SQ_STAGES];
    logic [SQ_W-1:0]         s_n_reg [0:SQ_STAGES-1];
    logic [ROOT_W-1:0]       s_q_reg [0:SQ_STAGES];
    logic [REM_W-1:0]        s_r_reg [0:SQ_STAGES];
    logic signed [IN_W-1:0]  s_x_reg [0:SQ_STAGES];
    logic signed [IN_W-1:0]  s_y_reg [0:SQ_STAGES];
    logic signed [IN_W-1:0]  s_z_reg [0:SQ_STAGES];

    logic [ROOT_W-1:0]       q_next [1:SQ_STAGES];
    logic [REM_W-1:0]        r_next [1:SQ_STAGES];

    assign xx_prod = in_x * in_x;
    assign zz_prod = in_z * in_z;

    // One root bit per stage, most significant radicand pair first
    for (genvar k = 1; k <= SQ_STAGES; k++)
    begin : g_step
        localparam int P = SQ_STAGES - k;
        logic [1:0]       pair;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] sub;
        logic [REM_W+1:0] diff;
        logic             fits;

        // Low radicand pairs are the zero padding
        if (2 * P >= SQ_PAD)
        begin : g_data
            assign pair = s_n_reg[k-1][2*P-SQ_PAD+1 -: 2];
        end
        else
        begin : g_pad
            assign pair = 2'b00;
        end

        assign trial     = {s_r_reg[k-1], pair};
        assign sub       = {1'b0, s_q_reg[k-1], 2'b01};
        assign diff      = trial - sub;
        assign fits      = (trial >= sub);
        assign q_next[k] = {s_q_reg[k-1][ROOT_W-2:0], fits};
        assign r_next[k] = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqa_v_reg <= 1'b0;
            for (int k = 0; k <= SQ_STAGES; k++)
            begin
                s_v_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            sqa_v_reg  <= in_valid;
            s_v_reg[0] <= sqa_v_reg;
            for (int k = 1; k <= SQ_STAGES; k++)
            begin
                s_v_reg[k] <= s_v_reg[k-1];
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            xx_reg <= xx_prod[SQ_W-2:0];
            zz_reg <= zz_prod[SQ_W-2:0];
            ax_reg <= in_x;
            ay_reg <= in_y;
            az_reg <= in_z;

            s_n_reg[0] <= {1'b0, xx_reg} + {1'b0, zz_reg};
            s_q_reg[0] <= '0;
            s_r_reg[0] <= '0;
            s_x_reg[0] <= ax_reg;
            s_y_reg[0] <= ay_reg;
            s_z_reg[0] <= az_reg;

            for (int k = 1; k <= SQ_STAGES; k++)
            begin
                s_q_reg[k] <= q_next[k];
                s_r_reg[k] <= r_next[k];
                s_x_reg[k] <= s_x_reg[k-1];
                s_y_reg[k] <= s_y_reg[k-1];
                s_z_reg[k] <= s_z_reg[k-1];
            end
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                s_n_reg[k] <= s_n_reg[k-1];
            end
        end
    end

    assign out_valid = s_v_reg[SQ_STAGES];
    assign out_root  = s_q_reg[SQ_STAGES];
    assign out_x     = s_x_reg[SQ_STAGES];
    assign out_y     = s_y_reg[SQ_STAGES];
    assign out_z     = s_z_reg[SQ_STAGES];

    // A floor root leaves a remainder of at most twice the root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s_v_reg[SQ_STAGES] |-> (s_r_reg[SQ_STAGES] <= {s_q_reg[SQ_STAGES], 1'b0}))
        else $error("square root remainder out of bound");

endmodule

[rtl/atl_cordic.sv]
// Two-lane vectoring CORDIC pipeline computing atan2(num, den) in 1/25600 degree.
// Handles zero operands and the left half plane before the rotations. Uses atl_pkg.
`timescale 1ns / 1ps

module atl_cordic
    import atl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  ce,
    input  logic  in_valid,
    input  cw_t   in_num [NLANE],
    input  cw_t   in_den [NLANE],
    output logic  out_valid,
    output ang_t  out_angle [NLANE]
);

    // Stage 0 is the quadrant fold, stage k has done k rotations
    logic  c_v_reg    [0:CORDIC_STAGES];
    cw_t   c_a_reg    [0:CORDIC_STAGES][NLANE];
    cw_t   c_b_reg    [0:CORDIC_STAGES][NLANE];
    ang_t  c_ang_reg  [0:CORDIC_STAGES][NLANE];
    ang_t  c_base_reg [0:CORDIC_STAGES][NLANE];
    logic  c_fix_reg  [0:CORDIC_STAGES][NLANE];
    logic  o_v_reg;
    ang_t  o_ang_reg  [NLANE];

    cw_t   a_next     [0:CORDIC_STAGES][NLANE];
    cw_t   b_next     [0:CORDIC_STAGES][NLANE];
    ang_t  ang_next   [0:CORDIC_STAGES][NLANE];
    ang_t  base_next  [NLANE];
    logic  fix_next   [NLANE];

    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        logic zero_b;
        logic zero_a;
        logic neg_a;
        logic pos_b;

        // Fold the left half plane and pin the axis cases
        assign zero_b = (in_num[l] == '0);
        assign zero_a = (in_den[l] == '0);
        assign neg_a  = in_den[l][CW-1];
        assign pos_b  = (in_num[l] > 0);

        assign fix_next[l]  = zero_b | zero_a;
        assign base_next[l] = zero_b ? (neg_a ? -DEG180 : '0) :
                              zero_a ? (pos_b ? DEG90 : -DEG90) :
                              neg_a  ? (pos_b ? DEG180 : -DEG180) : '0;
        assign a_next[0][l]   = neg_a ? -in_den[l] : in_den[l];
        assign b_next[0][l]   = neg_a ? -in_num[l] : in_num[l];
        assign ang_next[0][l] = '0;

        // Rotate toward the positive x axis, one micro-rotation per stage
        for (genvar k = 1; k <= CORDIC_STAGES; k++)
        begin : g_rot
            localparam int I = k - 1;
            logic up;
            cw_t  a_sh;
            cw_t  b_sh;

            assign up   = (c_b_reg[k-1][l] > 0);
            assign a_sh = c_a_reg[k-1][l] >>> I;
            assign b_sh = c_b_reg[k-1][l] >>> I;

            assign a_next[k][l]   = up ? c_a_reg[k-1][l] + b_sh : c_a_reg[k-1][l] - b_sh;
            assign b_next[k][l]   = up ? c_b_reg[k-1][l] - a_sh : c_b_reg[k-1][l] + a_sh;
            assign ang_next[k][l] = up ? c_ang_reg[k-1][l] + ATAN_TAB[I]
                                       : c_ang_reg[k-1][l] - ATAN_TAB[I];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                c_v_reg[k] <= 1'b0;
            end
            o_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            c_v_reg[0] <= in_valid;
            for (int k = 1; k <= CORDIC_STAGES; k++)
            begin
                c_v_reg[k] <= c_v_reg[k-1];
            end
            o_v_reg <= c_v_reg[CORDIC_STAGES];
        end
    end

    // Advance payload and add the quadrant base at the end
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                c_base_reg[0][l] <= base_next[l];
                c_fix_reg[0][l]  <= fix_next[l];
                for (int k = 0; k <= CORDIC_STAGES; k++)
                begin
                    c_a_reg[k][l]   <= a_next[k][l];
                    c_b_reg[k][l]   <= b_next[k][l];
                    c_ang_reg[k][l] <= ang_next[k][l];
                end
                for (int k = 1; k <= CORDIC_STAGES; k++)
                begin
                    c_base_reg[k][l] <= c_base_reg[k-1][l];
                    c_fix_reg[k][l]  <= c_fix_reg[k-1][l];
                end
                o_ang_reg[l] <= c_fix_reg[CORDIC_STAGES][l]
                              ? c_base_reg[CORDIC_STAGES][l]
                              : c_base_reg[CORDIC_STAGES][l] + c_ang_reg[CORDIC_STAGES][l];
            end
        end
    end

    assign out_valid = o_v_reg;
    assign out_angle = o_ang_reg;

endmodule

[rtl/atl_outq.sv]
// Rounding to centidegrees with range clamp, then a two-entry result queue.
// The queue fill sets the pipeline advance enable. Uses atl_pkg.
`timescale 1ns / 1ps

module atl_outq
    import atl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ang_t                       in_angle [NLANE],
    output logic                       ce,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [PITCH_W-1:0]  pitch_centideg,
    output logic signed [ROLL_W-1:0]   roll_centideg
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);
    localparam int HALF   = 2 ** (ANG_FRAC - 1);

    // Round half away from zero, then clamp to +/- lim
    function automatic cdeg_t round_clamp(input ang_t v, input cdeg_t lim);
        logic [ANG_W:0] biased;
        cdeg_t          q;
        biased = {v[ANG_W-1], v} + (v[ANG_W-1] ? (ANG_W+1)'(HALF - 1) : (ANG_W+1)'(HALF));
        q      = biased[ANG_W:ANG_FRAC];
        return (q > lim) ? lim : ((q < -lim) ? -lim : q);
    endfunction

    logic                       r_v_reg;
    logic signed [PITCH_W-1:0]  r_pitch_reg;
    logic signed [ROLL_W-1:0]   r_roll_reg;
    cdeg_t                      pitch_rnd;
    cdeg_t                      roll_rnd;

    logic signed [PITCH_W-1:0]  pitch_mem [QDEPTH];
    logic signed [ROLL_W-1:0]   roll_mem  [QDEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       push;
    logic                       pop;

    assign pitch_rnd = round_clamp(in_angle[LANE_PITCH], PITCH_LIM);
    assign roll_rnd  = round_clamp(in_angle[LANE_ROLL], ROLL_LIM);

    // Hold the whole pipeline while the queue is full
    assign ce         = (count_reg != CNT_W'(QDEPTH));
    assign push       = ce & r_v_reg;
    assign pop        = out_valid & ~out_stall;
    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    assign out_valid  = (count_reg != '0);

    // Rounding stage valid and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ce)
            begin
                r_v_reg <= in_valid;
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Rounding stage payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_pitch_reg <= pitch_rnd[PITCH_W-1:0];
            r_roll_reg  <= roll_rnd[ROLL_W-1:0];
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pitch_mem[wr_ptr_reg] <= r_pitch_reg;
            roll_mem[wr_ptr_reg]  <= r_roll_reg;
        end
    end

    assign pitch_centideg = pitch_mem[rd_ptr_reg];
    assign roll_centideg  = roll_mem[rd_ptr_reg];

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_centideg >= -PITCH_LIM && pitch_centideg <= PITCH_LIM &&
                       roll_centideg >= -ROLL_LIM && roll_centideg <= ROLL_LIM))
        else $error("tilt angle out of range");

endmodule

[rtl/accel_tilt_angles_core.sv]
// Tilt angles from one accelerometer sample: pitch and roll in centidegrees.
// Top level; instantiates atl_sqrt, atl_cordic and atl_outq, uses atl_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one signed sample accel_x,
//   accel_y, accel_z per transaction. Output channel (out_valid / out_stall)
//   carries pitch_centideg = atan2(y, sqrt(x^2+z^2)) and
//   roll_centideg = atan2(-x, z), rounded to nearest hundredth of a degree.
//   Throughput: one transaction per cycle on each side while that side is not stalled.
//   Pipeline, in order: 2 square/sum stages, 24 square-root stages (one
//   root bit each), 1 quadrant fold, 22 CORDIC rotations, 1 final add,
//   1 rounding stage.
//   A two-entry result queue sits at the output. When it is full, the whole
//   pipeline holds in place and in_stall goes high; nothing is lost or
//   repeated. in_stall comes from registered state only.
//   Reset (rst_n low) empties the pipeline and the queue; there is no
//   configuration and no other state.
`timescale 1ns / 1ps

module accel_tilt_angles_core
    import atl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IN_W-1:0]     accel_x,
    input  logic signed [IN_W-1:0]     accel_y,
    input  logic signed [IN_W-1:0]     accel_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [PITCH_W-1:0]  pitch_centideg,
    output logic signed [ROLL_W-1:0]   roll_centideg
);

    logic                    ce;
    logic                    sq_valid;
    logic [ROOT_W-1:0]       root;
    logic signed [IN_W-1:0]  sx;
    logic signed [IN_W-1:0]  sy;
    logic signed [IN_W-1:0]  sz;
    logic signed [IN_W:0]    negx;
    cw_t                     num [NLANE];
    cw_t                     den [NLANE];
    logic                    cd_valid;
    ang_t                    angle [NLANE];

    assign in_stall = ~ce;

    atl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (in_valid),
        .in_x      (accel_x),
        .in_y      (accel_y),
        .in_z      (accel_z),
        .out_valid (sq_valid),
        .out_root  (root),
        .out_x     (sx),
        .out_y     (sy),
        .out_z     (sz)
    );

    // Scale operands: pitch uses (y, r), roll uses (-x, z)
    assign negx = -{sx[IN_W-1], sx};

    assign num[LANE_PITCH] = {{(CW-IN_W-OP_SHIFT){sy[IN_W-1]}}, sy, {OP_SHIFT{1'b0}}};
    assign den[LANE_PITCH] = {{(CW-ROOT_W-ROOT_SHIFT){1'b0}}, root, {ROOT_SHIFT{1'b0}}};
    assign num[LANE_ROLL]  = {{(CW-IN_W-1-OP_SHIFT){negx[IN_W]}}, negx, {OP_SHIFT{1'b0}}};
    assign den[LANE_ROLL]  = {{(CW-IN_W-OP_SHIFT){sz[IN_W-1]}}, sz, {OP_SHIFT{1'b0}}};

    atl_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_num    (num),
        .in_den    (den),
        .out_valid (cd_valid),
        .out_angle (angle)
    );

    atl_outq u_outq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (cd_valid),
        .in_angle       (angle),
        .ce             (ce),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pitch_centideg (pitch_centideg),
        .roll_centideg  (roll_centideg)
    );

    // Input backpressure only ever comes from a queue holding results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result queue");

endmodule
